// ===== design/taas_pkg.sv =====
// Shared types and constants for the temperature average / alarm / servo block.
// No dependencies; imported by taas_fifo and temperature_average_alarm_servo.
package taas_pkg;

  // field widths
  localparam int ADC_W    = 12;
  localparam int TEMP_W   = 15;
  localparam int PERIOD_W = 8;
  localparam int PULSE_W  = 21;
  localparam int LED_W    = 4;
  localparam int PHASE_W  = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam int ADC_MAX = 4095;

  // t16 = floor(TEMP_GAIN*sum / (TEMP_DIV*WINDOW)) - TEMP_OFFSET
  localparam int TEMP_GAIN   = 75;
  localparam int TEMP_DIV    = 16;
  localparam int TEMP_OFFSET = 4464;
  // unsigned quotient before the offset, max 19195
  localparam int QUOT_W      = 15;

  // pulse = floor(PULSE_GAIN*(t16-PULSE_REF)/16) + PULSE_BIAS, saturated
  localparam int PULSE_REF  = 320;
  localparam int PULSE_GAIN = 1925;
  localparam int PULSE_BIAS = 26000;
  localparam int PULSE_MAX  = 2097151;
  localparam int PULSE_PROD_W = 28;

  localparam logic signed [TEMP_W-1:0] THRESHOLD_RST = 15'sd960;
  localparam logic [PERIOD_W-1:0]      PERIOD_RST    = 8'd10;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_THRESHOLD = 1'b0,
    CFG_LED_PERIOD      = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] avg_temp;
    logic                     alarm;
    logic [LED_W-1:0]         led_mask;
    logic [PULSE_W-1:0]       pulse_length;
  } result_t;

endpackage

// ===== design/taas_fifo.sv =====
// Small output queue for result beats; decouples the pipeline from out_stall_i.
// Depends on taas_pkg (result_t, FIFO_* constants).
module taas_fifo
  import taas_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               push_data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output result_t               data_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  result_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/temperature_average_alarm_servo.sv =====
// Top level: moving-average temperature filter with LED alarm and servo pulse.
// Depends on taas_pkg and taas_fifo.
//
// Takes one 12-bit ADC beat per cycle unless stalled and returns one result beat
// per input beat, in order. The sample ring is a WINDOW-deep synchronous RAM;
// each beat does one read-modify-write of the oldest slot (old value read and
// new value written at the same edge), so the ring port sets the rate at one
// beat per clock. Entries never written since reset read as zero through a
// per-entry valid bit, so no clearing pass is needed after reset. The path from
// input acceptance to the output runs through ring read, running-sum update and
// phase step, constant-reciprocal divide by 16*WINDOW, correction plus alarm
// compare, then the servo multiply into an eight-entry output queue. in_stall_o
// rises only when the queue plus the beats in flight could fill it, so input
// keeps flowing while a result waits.
// Configuration (index 0: alarm threshold, index 1: LED period) is always
// accepted and should be written only while the block is idle.
module temperature_average_alarm_servo
  import taas_pkg::*;
#(
  parameter int WINDOW = 50
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ADC_W-1:0]             adc_sample_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [TEMP_W-1:0]     avg_temp_o,
  output logic                         alarm_o,
  output logic [LED_W-1:0]             led_mask_o,
  output logic [PULSE_W-1:0]           pulse_length_o,
  // configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = $clog2(WINDOW * ADC_MAX + 1);
  localparam int DIV    = TEMP_DIV * WINDOW;
  // floor(TEMP_GAIN * 2^SUM_W / DIV); quotient estimate is at most one low
  localparam longint MULT = (longint'(TEMP_GAIN) * (longint'(1) << SUM_W)) / DIV;
  localparam int MULT_W = $clog2(MULT + 1);
  localparam int PROD_W = SUM_W + MULT_W;
  localparam int X_W    = SUM_W + 7;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [TEMP_W-1:0] threshold_q;
  logic [PERIOD_W-1:0]      led_period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      led_period_q <= PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ALARM_THRESHOLD: threshold_q  <= cfg_data_i[TEMP_W-1:0];
        CFG_LED_PERIOD:      led_period_q <= cfg_data_i[PERIOD_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // flow control: the pipeline never stalls; admission is by queue room
  // ---------------------------------------------------------------------
  logic                  s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] in_flight;
  logic                  in_accept;

  assign in_flight  = FIFO_CNT_W'(s1_vld_q) + FIFO_CNT_W'(s2_vld_q)
                    + FIFO_CNT_W'(s3_vld_q) + FIFO_CNT_W'(s4_vld_q);
  assign in_stall_o = (fifo_count + in_flight) >= FIFO_CNT_W'(FIFO_DEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: ring read-modify-write at the write position
  // ---------------------------------------------------------------------
  logic [ADC_W-1:0]  ring_mem [WINDOW];
  logic [WINDOW-1:0] ring_vld_q;
  logic [POS_W-1:0]  wpos_q, wpos_d;
  logic [ADC_W-1:0]  old_rd_q;
  logic              old_vld_q;
  logic [ADC_W-1:0]  sample_q;

  always_comb begin
    wpos_d = wpos_q;
    if (in_accept) begin
      if (wpos_q == POS_W'(WINDOW - 1)) begin
        wpos_d = '0;
      end else begin
        wpos_d = wpos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      ring_vld_q <= '0;
    end else begin
      wpos_q <= wpos_d;
      if (in_accept) begin
        ring_vld_q[wpos_q] <= 1'b1;
      end
    end
  end

  // read returns the old entry when read and write hit the same slot
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      old_rd_q        <= ring_mem[wpos_q];
      ring_mem[wpos_q] <= adc_sample_i;
      old_vld_q       <= ring_vld_q[wpos_q];
      sample_q        <= adc_sample_i;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: running sum and LED phase
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [ADC_W-1:0]    old_sample;
  logic [PHASE_W-1:0]  phase_q, phase_d, phase_inc, span;
  logic [PERIOD_W-1:0] period;

  assign old_sample = old_vld_q ? old_rd_q : '0;
  assign period     = (led_period_q == '0) ? PERIOD_W'(1) : led_period_q;
  assign span       = {period, 2'b00};
  assign phase_inc  = phase_q + 1'b1;

  always_comb begin
    sum_d   = sum_q;
    phase_d = phase_q;
    if (s1_vld_q) begin
      sum_d   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
      phase_d = (phase_inc >= span) ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      phase_q <= '0;
    end else begin
      sum_q   <= sum_d;
      phase_q <= phase_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: quotient estimate by reciprocal, LED select from phase
  // (sum_q and phase_q hold this beat's values during this cycle)
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] recip_prod;
  logic [X_W-1:0]    scaled_sum;
  logic [LED_W-1:0]  led_sel;
  logic [QUOT_W-1:0] q0_q;
  logic [X_W-1:0]    scaled_q;
  logic [LED_W-1:0]  led_sel_q;

  assign recip_prod = PROD_W'(sum_q) * PROD_W'(MULT);
  assign scaled_sum = X_W'(sum_q) * X_W'(TEMP_GAIN);

  always_comb begin
    if (phase_q < PHASE_W'(period)) begin
      led_sel = 4'b0001;
    end else if (phase_q < (PHASE_W'(period) << 1)) begin
      led_sel = 4'b0010;
    end else if (phase_q < PHASE_W'(period) * PHASE_W'(3)) begin
      led_sel = 4'b0100;
    end else begin
      led_sel = 4'b1000;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q      <= recip_prod[SUM_W +: QUOT_W];
    scaled_q  <= scaled_sum;
    led_sel_q <= led_sel;
  end

  // ---------------------------------------------------------------------
  // stage 3: quotient correction, temperature and alarm
  // ---------------------------------------------------------------------
  logic [X_W-1:0]           remainder;
  logic [QUOT_W-1:0]        quot;
  logic signed [TEMP_W:0]   temp_wide;
  logic signed [TEMP_W-1:0] temp;
  logic                     alarm;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     alarm_q;
  logic [LED_W-1:0]         led_mask_q;

  assign remainder = scaled_q - X_W'(q0_q) * X_W'(DIV);
  assign quot      = (remainder >= X_W'(DIV)) ? q0_q + 1'b1 : q0_q;
  assign temp_wide = $signed({1'b0, quot}) - (TEMP_W+1)'(TEMP_OFFSET);
  assign temp      = temp_wide[TEMP_W-1:0];
  assign alarm     = temp >= threshold_q;

  always_ff @(posedge clk_i) begin
    temp_q     <= temp;
    alarm_q    <= alarm;
    led_mask_q <= alarm ? led_sel_q : '0;
  end

  // ---------------------------------------------------------------------
  // stage 4: servo pulse, floor division by 16 via arithmetic shift
  // ---------------------------------------------------------------------
  logic signed [PULSE_PROD_W-1:0] temp_rel;
  logic signed [PULSE_PROD_W-1:0] pulse_prod;
  logic signed [PULSE_PROD_W-1:0] pulse_raw;
  logic [PULSE_W-1:0]             pulse;
  result_t                        result;

  assign temp_rel   = PULSE_PROD_W'(temp_q) - PULSE_PROD_W'(PULSE_REF);
  assign pulse_prod = temp_rel * $signed(PULSE_PROD_W'(PULSE_GAIN));
  assign pulse_raw  = (pulse_prod >>> 4) + $signed(PULSE_PROD_W'(PULSE_BIAS));

  always_comb begin
    if (pulse_raw < 0) begin
      pulse = '0;
    end else if (pulse_raw > $signed(PULSE_PROD_W'(PULSE_MAX))) begin
      pulse = PULSE_W'(PULSE_MAX);
    end else begin
      pulse = pulse_raw[PULSE_W-1:0];
    end
  end

  always_comb begin
    result.avg_temp     = temp_q;
    result.alarm        = alarm_q;
    result.led_mask     = led_mask_q;
    result.pulse_length = pulse;
  end

  // ---------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------
  result_t out_beat;

  taas_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s4_vld_q),
    .push_data_i (result),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (out_beat),
    .count_o     (fifo_count)
  );

  assign avg_temp_o     = out_beat.avg_temp;
  assign alarm_o        = out_beat.alarm;
  assign led_mask_o     = out_beat.led_mask;
  assign pulse_length_o = out_beat.pulse_length;

endmodule
